FILE: design/hhc_pkg.sv
// Shared types, address decode and register masks for the high memory map core.
package hhc_pkg;

  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_BUTTON = 2'd2;
  localparam logic [1:0] KIND_TICKS  = 2'd3;

  localparam int WRAM_DEPTH = 8192;
  localparam int WRAM_AW    = $clog2(WRAM_DEPTH);
  localparam int HRAM_DEPTH = 127;
  localparam int HRAM_AW    = 7;
  localparam int SND_DEPTH  = 20;
  localparam int SCTL_DEPTH = 3;
  localparam int WAVE_DEPTH = 16;

  localparam logic [7:0] PAD_RESET  = 8'hCF;
  localparam logic [7:0] SCTRL_BASE = 8'h7E;
  localparam logic [7:0] TAC_BASE   = 8'hF8;
  localparam logic [7:0] IF_BASE    = 8'hE0;
  localparam logic [7:0] OPEN_BUS   = 8'hFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [15:0] write_data;
    logic        wide;
    logic [2:0]  button_number;
    logic        button_released;
    logic [7:0]  tick_count;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        serial_valid;
    logic [7:0]  serial_byte;
    logic        boot_rom_off;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_COLLECT
  } state_t;

  typedef enum logic [3:0] {
    R_NONE, R_WRAM, R_HRAM, R_IE, R_PAD, R_SDATA, R_SCTRL, R_DIV,
    R_TIMA, R_TMA, R_TAC, R_IF, R_SND, R_SCTL, R_WAVE, R_BOOT
  } region_t;

  function automatic region_t decode(input logic [15:0] a);
    region_t r;
    r = R_NONE;
    if (a >= 16'hC000 && a < 16'hFF00)      r = R_WRAM;
    else if (a == 16'hFFFF)                 r = R_IE;
    else if (a >= 16'hFF80)                 r = R_HRAM;
    else if (a == 16'hFF00)                 r = R_PAD;
    else if (a == 16'hFF01)                 r = R_SDATA;
    else if (a == 16'hFF02)                 r = R_SCTRL;
    else if (a == 16'hFF04)                 r = R_DIV;
    else if (a == 16'hFF05)                 r = R_TIMA;
    else if (a == 16'hFF06)                 r = R_TMA;
    else if (a == 16'hFF07)                 r = R_TAC;
    else if (a == 16'hFF0F)                 r = R_IF;
    else if (a >= 16'hFF10 && a <= 16'hFF23) r = R_SND;
    else if (a >= 16'hFF24 && a <= 16'hFF26) r = R_SCTL;
    else if (a >= 16'hFF30 && a <= 16'hFF3F) r = R_WAVE;
    else if (a == 16'hFF50)                 r = R_BOOT;
    return r;
  endfunction

  function automatic logic [7:0] snd_mask(input logic [4:0] idx);
    logic [7:0] m;
    case (idx)
      5'd0:    m = 8'h80;
      5'd1:    m = 8'h3F;
      5'd4:    m = 8'hB8;
      5'd5:    m = 8'hFF;
      5'd6:    m = 8'h3F;
      5'd9:    m = 8'hB8;
      5'd10:   m = 8'h7F;
      5'd11:   m = 8'hFF;
      5'd12:   m = 8'h9F;
      5'd14:   m = 8'hB8;
      5'd15:   m = 8'hFF;
      5'd16:   m = 8'hFF;
      5'd19:   m = 8'hBF;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] sctl_mask(input logic [1:0] idx);
    return (idx == 2'd2) ? 8'h70 : 8'h00;
  endfunction

endpackage

FILE: design/handheld_console_high_memory_map_core.sv
// Top level: upper bus map with work RAM, high RAM and I/O registers.
//
// Usage: drive item and raise start; the item is taken at a rising edge
// where start is high and busy is low. Kinds are bus read, bus write,
// button change and clock ticks. Each item produces exactly one result,
// shown on result for one cycle with done high; the receiver cannot hold
// it off and must take it in that cycle.
// Work RAM and high RAM are synchronous memories with registered read
// data; every byte access goes through them or the register file one
// byte per step, so a sixteen-bit access runs two byte steps back to back.
// Done shows in the cycle that busy falls, so the next start can be taken
// with it. A read step is an issue state plus a collect state that picks
// up the read byte; a write, button change or clock ticks step has only
// the exec state. Reset sets the I/O registers and the control state to
// their power-up values; RAM contents stay undefined until written. No
// clearing sequence follows reset.
module handheld_console_high_memory_map_core
  import hhc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t item,
  output logic busy,
  output logic done,
  output rsp_t result
);

  state_t state, state_next;
  req_t   req;
  logic   phase;
  logic   finish;

  logic [7:0] wram [WRAM_DEPTH];
  logic [7:0] hram [HRAM_DEPTH];
  logic [7:0] wram_q, hram_q;

  logic [7:0] snd   [SND_DEPTH];
  logic [7:0] sctl  [SCTL_DEPTH];
  logic [7:0] wave  [WAVE_DEPTH];
  logic [7:0] pad_reg, button_levels, ser_data, ser_ctrl;
  logic [15:0] div_cycles;
  logic [7:0] tim_count, tim_modulo, tim_ctrl, irq_flag, irq_enable;
  logic       boot_disabled;

  logic [7:0] reg_q, rd_lo;
  region_t    region_q;
  logic       sent, boot_ev;
  logic [7:0] sent_byte;

  logic [15:0] cur_addr;
  logic [7:0]  cur_data, reg_byte, col_byte, pad_val;
  region_t     region;
  logic [4:0]  snd_idx;
  logic [1:0]  sctl_idx;
  logic        do_write, ser_fire, boot_fire;

  assign cur_addr = req.address + {15'd0, phase};
  assign cur_data = phase ? req.write_data[15:8] : req.write_data[7:0];
  assign region   = decode(cur_addr);
  assign snd_idx  = 5'(cur_addr[7:0] - 8'h10);
  assign sctl_idx = 2'(cur_addr[7:0] - 8'h24);
  assign do_write = (state == S_EXEC) && (req.kind == KIND_WRITE);
  assign ser_fire = do_write && (region == R_SCTRL) && cur_data[7];
  assign boot_fire = do_write && (region == R_BOOT) && !boot_disabled;
  assign busy     = (state != S_IDLE);

  always_comb begin
    pad_val = PAD_RESET | cur_data;
    if (!pad_val[4]) pad_val[3:0] = pad_val[3:0] & button_levels[3:0];
    if (!pad_val[5]) pad_val[3:0] = pad_val[3:0] & button_levels[7:4];
  end

  always_comb begin
    unique case (region)
      R_IE:    reg_byte = irq_enable;
      R_PAD:   reg_byte = pad_reg;
      R_SDATA: reg_byte = ser_data;
      R_SCTRL: reg_byte = ser_ctrl;
      R_DIV:   reg_byte = div_cycles[15:8];
      R_TIMA:  reg_byte = tim_count;
      R_TMA:   reg_byte = tim_modulo;
      R_TAC:   reg_byte = tim_ctrl;
      R_IF:    reg_byte = irq_flag;
      R_SND:   reg_byte = snd[snd_idx];
      R_SCTL:  reg_byte = sctl[sctl_idx];
      R_WAVE:  reg_byte = wave[cur_addr[3:0]];
      default: reg_byte = OPEN_BUS;
    endcase
  end

  always_comb begin
    case (region_q)
      R_WRAM:  col_byte = wram_q;
      R_HRAM:  col_byte = hram_q;
      default: col_byte = reg_q;
    endcase
  end

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (req.kind == KIND_READ) begin
          state_next = S_COLLECT;
        end else if (req.kind == KIND_WRITE && req.wide && !phase) begin
          state_next = S_EXEC;
        end else begin
          state_next = S_IDLE;
          finish     = 1'b1;
        end
      end
      S_COLLECT: begin
        if (req.wide && !phase) begin
          state_next = S_EXEC;
        end else begin
          state_next = S_IDLE;
          finish     = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (do_write && region == R_WRAM) wram[cur_addr[WRAM_AW-1:0]] <= cur_data;
    wram_q <= wram[cur_addr[WRAM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (do_write && region == R_HRAM) hram[cur_addr[HRAM_AW-1:0]] <= cur_data;
    hram_q <= hram[cur_addr[HRAM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) req <= item;
    if (state == S_EXEC) begin
      reg_q    <= reg_byte;
      region_q <= region;
    end
    if (state == S_COLLECT && !phase) rd_lo <= col_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      sent      <= 1'b0;
      sent_byte <= 8'h00;
      boot_ev   <= 1'b0;
    end else if (state == S_IDLE && start) begin
      phase     <= 1'b0;
      sent      <= 1'b0;
      sent_byte <= 8'h00;
      boot_ev   <= 1'b0;
    end else begin
      if ((state == S_EXEC && do_write && req.wide && !phase) ||
          (state == S_COLLECT && req.wide && !phase)) begin
        phase <= 1'b1;
      end
      if (ser_fire) begin
        sent      <= 1'b1;
        sent_byte <= ser_data;
      end
      if (boot_fire) boot_ev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SND_DEPTH; i++) snd[i] <= snd_mask(5'(i));
      for (int i = 0; i < SCTL_DEPTH; i++) sctl[i] <= sctl_mask(2'(i));
      for (int i = 0; i < WAVE_DEPTH; i++) wave[i] <= 8'h00;
      pad_reg       <= PAD_RESET;
      button_levels <= 8'hFF;
      ser_data      <= 8'h00;
      ser_ctrl      <= SCTRL_BASE;
      div_cycles    <= 16'h0000;
      tim_count     <= 8'h00;
      tim_modulo    <= 8'h00;
      tim_ctrl      <= TAC_BASE;
      irq_flag      <= IF_BASE;
      irq_enable    <= 8'h00;
      boot_disabled <= 1'b0;
    end else if (state == S_EXEC) begin
      if (req.kind == KIND_BUTTON) begin
        button_levels[req.button_number] <= req.button_released;
      end
      if (req.kind == KIND_TICKS) begin
        div_cycles <= div_cycles + {8'h00, req.tick_count};
      end
      if (do_write) begin
        unique case (region)
          R_IE:    irq_enable <= cur_data;
          R_PAD:   pad_reg <= pad_val;
          R_SDATA: ser_data <= cur_data;
          R_SCTRL: begin
            ser_ctrl <= SCTRL_BASE | {1'b0, cur_data[6:0]};
            if (cur_data[7]) ser_data <= 8'h00;
          end
          R_DIV:   div_cycles <= 16'h0000;
          R_TIMA:  tim_count <= cur_data;
          R_TMA:   tim_modulo <= cur_data;
          R_TAC:   tim_ctrl <= TAC_BASE | cur_data;
          R_IF:    irq_flag <= IF_BASE | cur_data;
          R_SND:   snd[snd_idx] <= snd_mask(snd_idx) | cur_data;
          R_SCTL:  sctl[sctl_idx] <= sctl_mask(sctl_idx) | cur_data;
          R_WAVE:  wave[cur_addr[3:0]] <= cur_data;
          R_BOOT:  boot_disabled <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= finish;
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (req.kind == KIND_READ) begin
        if (req.wide) result.read_data <= {col_byte, rd_lo};
        else result.read_data <= {OPEN_BUS, col_byte};
      end else begin
        result.read_data <= 16'h0000;
      end
      result.serial_valid <= sent | ser_fire;
      result.serial_byte  <= ser_fire ? ser_data : sent_byte;
      result.boot_rom_off <= boot_ev | boot_fire;
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start");

  a_phase_only_wide: assert property (@(posedge clk) disable iff (rst)
    (busy && phase) |-> req.wide)
    else $error("second byte step on a narrow access");

  a_sctrl_start_clear: assert property (@(posedge clk) disable iff (rst)
    ser_ctrl[7] == 1'b0)
    else $error("serial start bit left set");

  a_serial_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.serial_valid) |-> (result.serial_byte == 8'h00))
    else $error("serial byte set without transfer");

endmodule
